### sv/ekd_pkg.sv
// ----------------------------------------------------------------------------
// ekd_pkg
// Shared sizes and the command/status bundles that join the controller and
// the datapath of the exact-k distinct subarray counter.
// ----------------------------------------------------------------------------
package ekd_pkg;

    localparam int MAX_LEN     = 4096;
    localparam int VALUE_COUNT = 1024;

    localparam int VAL_W   = 10;                      // stream value
    localparam int ADDR_W  = $clog2(MAX_LEN);         // history address
    localparam int CNT_W   = $clog2(MAX_LEN + 1);     // pointers, item count, occurrences
    localparam int TAB_W   = $clog2(VALUE_COUNT);     // occurrence table address
    localparam int DIST_W  = 11;                      // distinct values in a window
    localparam int K_W     = 11;
    localparam int TOT_W   = 24;
    localparam int K_RESET = 1;

    typedef struct packed {
        logic clr;        // zero one entry of both occurrence tables
        logic take;       // word accepted on the input side
        logic inc;        // bump the new value in both tables
        logic hist_rd;    // read the history
        logic hist_inner; // history address from the inner pointer, else the left pointer
        logic cnt_rd;     // read the tables at the value just read from the history
        logic o_dec;      // drop the oldest item of the outer window
        logic i_dec;      // drop the oldest item of the inner window
        logic emit;       // load the result register
    } ekd_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic full;
        logic outer_move;
        logic inner_move;
        logic out_free;
        logic last;
    } ekd_sts_t;

endpackage

### sv/ekd_ctrl.sv
// ----------------------------------------------------------------------------
// ekd_ctrl
// Sequencer: clearing pass, table update for the new word, then the left and
// inner pointer walks, then the hand-off to the result register.
// ----------------------------------------------------------------------------
module ekd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ekd_pkg::ekd_sts_t sts,
    output ekd_pkg::ekd_cmd_t cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_INC   = 4'd2;
    localparam logic [3:0] S_OCHK  = 4'd3;
    localparam logic [3:0] S_OHIST = 4'd4;
    localparam logic [3:0] S_ODEC  = 4'd5;
    localparam logic [3:0] S_ICHK  = 4'd6;
    localparam logic [3:0] S_IHIST = 4'd7;
    localparam logic [3:0] S_IDEC  = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    // a word beyond the history length is only reported
                    state_next = sts.full ? S_EMIT : S_INC;
                end
            end
            S_INC: begin
                cmd.inc    = 1'b1;
                state_next = S_OCHK;
            end
            S_OCHK: begin
                if (sts.outer_move) begin
                    cmd.hist_rd = 1'b1;
                    state_next  = S_OHIST;
                end else begin
                    state_next = S_ICHK;
                end
            end
            S_OHIST: begin
                cmd.cnt_rd = 1'b1;
                state_next = S_ODEC;
            end
            S_ODEC: begin
                cmd.o_dec  = 1'b1;
                state_next = S_OCHK;
            end
            S_ICHK: begin
                if (sts.inner_move) begin
                    cmd.hist_rd    = 1'b1;
                    cmd.hist_inner = 1'b1;
                    state_next     = S_IHIST;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_IHIST: begin
                cmd.cnt_rd = 1'b1;
                state_next = S_IDEC;
            end
            S_IDEC: begin
                cmd.i_dec  = 1'b1;
                state_next = S_ICHK;
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = sts.last ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

### sv/ekd_datapath.sv
// ----------------------------------------------------------------------------
// ekd_datapath
// Value history, the two occurrence tables, pointers, distinct counts, the
// k register and the result register.
// ----------------------------------------------------------------------------
module ekd_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ekd_pkg::ekd_cmd_t             cmd,
    output ekd_pkg::ekd_sts_t             sts,
    input  logic [ekd_pkg::VAL_W-1:0]     s_value,
    input  logic                          s_last,
    input  logic                          cfg_we,
    input  logic [ekd_pkg::K_W-1:0]       cfg_wdata,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [ekd_pkg::CNT_W-1:0]     m_count,
    output logic [ekd_pkg::TOT_W-1:0]     m_total,
    output logic                          m_overflow,
    output logic                          m_last
);

    // memories
    logic [ekd_pkg::VAL_W-1:0] hist_mem  [ekd_pkg::MAX_LEN];
    logic [ekd_pkg::CNT_W-1:0] outer_mem [ekd_pkg::VALUE_COUNT];
    logic [ekd_pkg::CNT_W-1:0] inner_mem [ekd_pkg::VALUE_COUNT];

    logic [ekd_pkg::VAL_W-1:0]  hist_q;
    logic [ekd_pkg::CNT_W-1:0]  outer_q;
    logic [ekd_pkg::CNT_W-1:0]  inner_q;
    logic [ekd_pkg::ADDR_W-1:0] hist_addr;
    logic [ekd_pkg::TAB_W-1:0]  cnt_rd_addr;
    logic [ekd_pkg::TAB_W-1:0]  cnt_wr_addr;
    logic [ekd_pkg::CNT_W-1:0]  outer_wdata;
    logic [ekd_pkg::CNT_W-1:0]  inner_wdata;
    logic                       outer_we;
    logic                       inner_we;
    logic                       store;

    // control and stream state
    logic [ekd_pkg::TAB_W-1:0]  clr_addr_reg;
    logic [ekd_pkg::K_W-1:0]    k_reg;
    logic [ekd_pkg::CNT_W-1:0]  items_reg;
    logic [ekd_pkg::CNT_W-1:0]  left_reg;
    logic [ekd_pkg::CNT_W-1:0]  inner_reg;
    logic [ekd_pkg::DIST_W-1:0] outer_dist_reg;
    logic [ekd_pkg::DIST_W-1:0] inner_dist_reg;
    logic [ekd_pkg::TOT_W-1:0]  total_reg;
    logic                       overflow_reg;
    logic                       drop_reg;
    logic                       last_reg;
    logic [ekd_pkg::VAL_W-1:0]  v_reg;

    // result register
    logic                       m_tvalid_reg;
    logic [ekd_pkg::CNT_W-1:0]  m_count_reg;
    logic [ekd_pkg::TOT_W-1:0]  m_total_reg;
    logic                       m_overflow_reg;
    logic                       m_last_reg;

    logic [ekd_pkg::CNT_W-1:0]  count;
    logic [ekd_pkg::CNT_W-1:0]  count_next;
    logic [ekd_pkg::TOT_W-1:0]  total_next;
    logic                       stream_end;

    assign store       = cmd.take && !sts.full;
    assign stream_end  = cmd.emit && last_reg;
    assign hist_addr   = cmd.hist_inner ? inner_reg[ekd_pkg::ADDR_W-1:0]
                                        : left_reg[ekd_pkg::ADDR_W-1:0];
    assign cnt_rd_addr = cmd.take ? s_value : hist_q;
    assign cnt_wr_addr = cmd.clr ? clr_addr_reg : (cmd.inc ? v_reg : hist_q);
    assign outer_we    = cmd.clr || cmd.inc || cmd.o_dec;
    assign inner_we    = cmd.clr || cmd.inc || cmd.i_dec;

    always_comb begin
        if (cmd.clr) begin
            outer_wdata = '0;
            inner_wdata = '0;
        end else if (cmd.inc) begin
            outer_wdata = outer_q + ekd_pkg::CNT_W'(1);
            inner_wdata = inner_q + ekd_pkg::CNT_W'(1);
        end else begin
            outer_wdata = outer_q - ekd_pkg::CNT_W'(1);
            inner_wdata = inner_q - ekd_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (store) begin
            hist_mem[items_reg[ekd_pkg::ADDR_W-1:0]] <= s_value;
        end
        if (cmd.hist_rd) begin
            hist_q <= hist_mem[hist_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (outer_we) begin
            outer_mem[cnt_wr_addr] <= outer_wdata;
        end
        if (cmd.take || cmd.cnt_rd) begin
            outer_q <= outer_mem[cnt_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (inner_we) begin
            inner_mem[cnt_wr_addr] <= inner_wdata;
        end
        if (cmd.take || cmd.cnt_rd) begin
            inner_q <= inner_mem[cnt_rd_addr];
        end
    end

    // status
    assign sts.clr_done   = (clr_addr_reg == '1);
    assign sts.full       = (items_reg == ekd_pkg::CNT_W'(ekd_pkg::MAX_LEN));
    assign sts.outer_move = (outer_dist_reg > k_reg) && (left_reg < items_reg);
    assign sts.inner_move = (inner_reg < items_reg) &&
                            ((inner_dist_reg >= k_reg) || (inner_reg < left_reg));
    assign sts.out_free   = !m_tvalid_reg || m_tready;
    assign sts.last       = last_reg;

    assign count      = (inner_reg > left_reg) ? (inner_reg - left_reg) : '0;
    assign count_next = drop_reg ? '0 : count;
    assign total_next = total_reg + ekd_pkg::TOT_W'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg   <= '0;
            k_reg          <= ekd_pkg::K_W'(ekd_pkg::K_RESET);
            items_reg      <= '0;
            left_reg       <= '0;
            inner_reg      <= '0;
            outer_dist_reg <= '0;
            inner_dist_reg <= '0;
            total_reg      <= '0;
            overflow_reg   <= 1'b0;
            drop_reg       <= 1'b0;
            last_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                k_reg <= cfg_wdata;
            end
            if (cmd.clr) begin
                clr_addr_reg <= clr_addr_reg + ekd_pkg::TAB_W'(1);
            end
            if (cmd.take) begin
                drop_reg <= sts.full;
                last_reg <= s_last;
                if (sts.full) begin
                    overflow_reg <= 1'b1;
                end
            end
            if (store) begin
                items_reg <= items_reg + ekd_pkg::CNT_W'(1);
            end
            if (cmd.inc) begin
                if (outer_q == '0) begin
                    outer_dist_reg <= outer_dist_reg + ekd_pkg::DIST_W'(1);
                end
                if (inner_q == '0) begin
                    inner_dist_reg <= inner_dist_reg + ekd_pkg::DIST_W'(1);
                end
            end
            if (cmd.o_dec) begin
                left_reg <= left_reg + ekd_pkg::CNT_W'(1);
                if (outer_q == ekd_pkg::CNT_W'(1)) begin
                    outer_dist_reg <= outer_dist_reg - ekd_pkg::DIST_W'(1);
                end
            end
            if (cmd.i_dec) begin
                inner_reg <= inner_reg + ekd_pkg::CNT_W'(1);
                if (inner_q == ekd_pkg::CNT_W'(1)) begin
                    inner_dist_reg <= inner_dist_reg - ekd_pkg::DIST_W'(1);
                end
            end
            if (cmd.emit) begin
                total_reg <= stream_end ? '0 : total_next;
            end
            // end of stream: back to an empty stream, tables are zeroed by the clearing pass
            if (stream_end) begin
                items_reg      <= '0;
                left_reg       <= '0;
                inner_reg      <= '0;
                outer_dist_reg <= '0;
                inner_dist_reg <= '0;
                overflow_reg   <= 1'b0;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            v_reg <= s_value;
        end
        if (cmd.emit) begin
            m_count_reg    <= count_next;
            m_total_reg    <= total_next;
            m_overflow_reg <= overflow_reg;
            m_last_reg     <= last_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_count    = m_count_reg;
    assign m_total    = m_total_reg;
    assign m_overflow = m_overflow_reg;
    assign m_last     = m_last_reg;

endmodule

### sv/exact_k_distinct_subarray_counter.sv
// ----------------------------------------------------------------------------
// exact_k_distinct_subarray_counter
// Counts, for each incoming value, the subarrays ending at it that hold
// exactly k distinct values, with a running total per stream.
// ----------------------------------------------------------------------------
// Input words carry one value (s_tdata) and the end-of-stream mark (s_tlast).
// Each accepted word gives one result word: the count for that item and the
// running total in m_tdata, the overflow flag in m_tuser and a copy of the
// end-of-stream mark in m_tlast. k is written through cfg_we/cfg_wdata by the
// user only while the block is idle; the block does not enforce it. k resets
// to 1 and survives the end of a stream. An item passes the table update, the
// left and inner pointer walks and the hand-off to the result register; each
// pointer step is a history read, a table read and a table write, on one port
// each. Unless the item was marked last, the next word is accepted in the
// cycle after the result register is loaded. Each pointer steps at most once
// per item on average. Items past the 4096th of a stream are not counted; they
// raise overflow. After reset and after each item marked last, a clearing pass
// zeroes both occurrence tables, one entry per cycle, with s_tready low.
// The result register lets the next word be accepted while a result waits;
// while m_tready stays low the block holds at the following result.
// ----------------------------------------------------------------------------
module exact_k_distinct_subarray_counter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [9:0] value, [15:10] zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [12:0] ends_here_count, [36:13] running_total,
                                    // [39:37] zero
    output logic        m_tuser,    // [0] overflow
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata
);

    ekd_pkg::ekd_cmd_t          cmd;
    ekd_pkg::ekd_sts_t          sts;
    logic [ekd_pkg::CNT_W-1:0]  m_count;
    logic [ekd_pkg::TOT_W-1:0]  m_total;

    ekd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ekd_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .s_value    (s_tdata[ekd_pkg::VAL_W-1:0]),
        .s_last     (s_tlast),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_count    (m_count),
        .m_total    (m_total),
        .m_overflow (m_tuser),
        .m_last     (m_tlast)
    );

    assign m_tdata = {3'b000, m_total, m_count};

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the exact-k distinct subarray counter. A built-in
// two-window predictor tracks every accepted word and each result word is
// compared field by field with the oldest prediction. The run covers directed
// streams, the value and k extremes, k changes within a stream, a stream long
// enough to overflow, and random streams with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_LIMIT = 100000;
    localparam int unsigned LONG_LEN   = ekd_pkg::MAX_LEN + 4;

    typedef struct packed {
        logic [12:0]               count;
        logic [ekd_pkg::TOT_W-1:0] total;
        logic                      ovf;
        logic                      last;
    } count_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic [10:0] cfg_wdata = '0;

    exact_k_distinct_subarray_counter DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // predictor state
    logic [ekd_pkg::VAL_W-1:0] hist_vals [0:ekd_pkg::MAX_LEN-1];
    int unsigned               occ_outer [0:ekd_pkg::VALUE_COUNT-1];
    int unsigned               occ_inner [0:ekd_pkg::VALUE_COUNT-1];
    int unsigned               dist_outer, dist_inner;
    int unsigned               left_ptr, inner_ptr, taken;
    logic [ekd_pkg::TOT_W-1:0] total_run;
    logic                      ovf_seen;
    int unsigned               k_now = ekd_pkg::K_RESET;

    count_result_t    pending_counts [$];
    int unsigned      err_count     = 0;
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_idle_pct = 0;
    int unsigned      recv_hold     = 0;
    int unsigned      quiet_cycles  = 0;

    function automatic void clear_windows();
        for (int i = 0; i < ekd_pkg::VALUE_COUNT; i++) begin
            occ_outer[i] = 0;
            occ_inner[i] = 0;
        end
        dist_outer = 0;
        dist_inner = 0;
        left_ptr   = 0;
        inner_ptr  = 0;
        taken      = 0;
        total_run  = '0;
        ovf_seen   = 1'b0;
    endfunction

    // Slide both windows over the new value and return the expected result.
    function automatic count_result_t count_subarrays_ending(
            input logic [ekd_pkg::VAL_W-1:0] val,
            input logic is_last);
        count_result_t res;
        int unsigned   cnt;
        int unsigned   w;
        cnt = 0;
        if (taken < ekd_pkg::MAX_LEN) begin
            hist_vals[taken] = val;
            taken++;
            if (occ_outer[val] == 0) dist_outer++;
            occ_outer[val]++;
            if (occ_inner[val] == 0) dist_inner++;
            occ_inner[val]++;
            while (dist_outer > k_now && left_ptr < taken) begin
                w = hist_vals[left_ptr];
                occ_outer[w]--;
                if (occ_outer[w] == 0) dist_outer--;
                left_ptr++;
            end
            // inner window holds at most k-1 values and never starts before left
            while (inner_ptr < taken && (dist_inner >= k_now || inner_ptr < left_ptr)) begin
                w = hist_vals[inner_ptr];
                occ_inner[w]--;
                if (occ_inner[w] == 0) dist_inner--;
                inner_ptr++;
            end
            cnt       = (inner_ptr > left_ptr) ? inner_ptr - left_ptr : 0;
            total_run = total_run + cnt[ekd_pkg::TOT_W-1:0];
        end else begin
            ovf_seen = 1'b1;
        end
        res.count = cnt[12:0];
        res.total = total_run;
        res.ovf   = ovf_seen;
        res.last  = is_last;
        if (is_last) clear_windows();
        return res;
    endfunction

    function automatic logic [ekd_pkg::K_W-1:0] pick_k();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ekd_pkg::K_W'(ekd_pkg::VALUE_COUNT);
            2:       return ekd_pkg::K_W'($urandom);
            default: return ekd_pkg::K_W'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic send_value(input logic [ekd_pkg::VAL_W-1:0] val, input logic is_last);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 16'(val);
        s_tlast  <= is_last;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        pending_counts.push_back(count_subarrays_ending(val, is_last));
    endtask

    task automatic send_list(input logic [ekd_pkg::VAL_W-1:0] vals [$],
                             input logic end_stream);
        for (int i = 0; i < vals.size(); i++)
            send_value(vals[i], end_stream && (i == vals.size() - 1));
    endtask

    // Drop valid and hold until every outstanding word has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge aclk);
    endtask

    task automatic write_k(input logic [ekd_pkg::K_W-1:0] kval);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= kval;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        k_now = kval;
    endtask

    task automatic test_reset_k();
        send_list('{10'd0, 10'd1023, 10'd1023, 10'h2AA, 10'h155, 10'd0}, 1'b1);
        send_list('{10'd5}, 1'b1);
        drain_results();
    endtask

    task automatic test_k_extremes();
        write_k('0);
        send_list('{10'd3, 10'd3, 10'd1023}, 1'b1);
        drain_results();
        write_k(ekd_pkg::K_W'(ekd_pkg::VALUE_COUNT));
        send_list('{10'd1, 10'd2, 10'd1}, 1'b1);
        drain_results();
        write_k('1);
        send_list('{10'd0, 10'd1}, 1'b1);
        drain_results();
    endtask

    task automatic test_k_midstream();
        write_k(ekd_pkg::K_W'(3));
        send_list('{10'd1, 10'd2, 10'd3, 10'd4, 10'd1}, 1'b0);
        drain_results();
        write_k(ekd_pkg::K_W'(1));
        send_list('{10'd1, 10'd1, 10'd2}, 1'b0);
        drain_results();
        write_k(ekd_pkg::K_W'(4));
        send_list('{10'd5, 10'd6, 10'd7, 10'd5}, 1'b1);
        drain_results();
    endtask

    // One run of equal values fills the history; the tail overflows.
    task automatic test_overflow();
        write_k(ekd_pkg::K_W'(1));
        for (int i = 0; i < LONG_LEN; i++)
            send_value(10'd1023, i == LONG_LEN - 1);
        drain_results();
    endtask

    task automatic test_backpressure();
        recv_hold = 300;
        for (int i = 0; i < 30; i++)
            send_value(ekd_pkg::VAL_W'($urandom_range(0, 3)), i == 29);
        drain_results();
    endtask

    task automatic test_random_streams(input int unsigned n_items,
                                       input int unsigned s_idle,
                                       input int unsigned r_idle);
        int unsigned               sent;
        int unsigned               len;
        int unsigned               alpha;
        logic [ekd_pkg::VAL_W-1:0] base;
        logic [ekd_pkg::VAL_W-1:0] v;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 1) == 1) begin
                drain_results();
                write_k(pick_k());
            end
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 300)
                                                : $urandom_range(1, 40);
            alpha = $urandom_range(1, 10);
            base  = ekd_pkg::VAL_W'($urandom);
            for (int i = 0; i < len; i++) begin
                if (i == len / 2 && $urandom_range(0, 7) == 0) begin
                    drain_results();
                    write_k(pick_k());
                end
                // mostly a small alphabet so the distinct count hovers near k
                if ($urandom_range(0, 9) == 0)
                    v = ekd_pkg::VAL_W'($urandom);
                else
                    v = base + ekd_pkg::VAL_W'($urandom_range(0, alpha - 1));
                send_value(v, i == len - 1);
            end
            sent += len;
        end
        drain_results();
    endtask

    always @(negedge aclk) begin
        if (recv_hold > 0) begin
            m_tready  <= 1'b0;
            recv_hold <= recv_hold - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        count_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_counts.size() == 0) begin
                $display("%0t: result word with none expected: count %0d total %0d",
                         $time, m_tdata[12:0], m_tdata[36:13]);
                err_count++;
            end else begin
                want = pending_counts.pop_front();
                if (m_tdata[12:0] !== want.count) begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.count, m_tdata[12:0]);
                    err_count++;
                end
                if (m_tdata[36:13] !== want.total) begin
                    $display("%0t: running total expected %0d actual %0d",
                             $time, want.total, m_tdata[36:13]);
                    err_count++;
                end
                if (m_tuser !== want.ovf) begin
                    $display("%0t: overflow expected %0b actual %0b",
                             $time, want.ovf, m_tuser);
                    err_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last expected %0b actual %0b",
                             $time, want.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    // Count cycles without a handshake on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clear_windows();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 71;
        test_reset_k();
        test_k_extremes();
        test_k_midstream();
        test_random_streams(310, 17, 71);
        test_random_streams(310, 71, 17);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_overflow();
        test_backpressure();
        test_random_streams(310, 0, 0);

        drain_results();
        repeat (50) @(posedge aclk);
        if (err_count == 0 && pending_counts.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
sv/ekd_pkg.sv
sv/ekd_ctrl.sv
sv/ekd_datapath.sv
sv/exact_k_distinct_subarray_counter.sv
tb/tb.sv
